### design/delta_block_size_calc_defines.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef DELTA_BLOCK_SIZE_CALC_DEFINES_SVH
`define DELTA_BLOCK_SIZE_CALC_DEFINES_SVH

// Same-cycle implication
`define DBSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DBSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dbsc_pkg.sv
`timescale 1ns / 1ps

package dbsc_pkg;

    // Parameter defaults
    localparam int MIN_BLOCK_DEF  = 700;
    localparam int BIAS_DEF       = 10;
    localparam int STRONG_LEN_DEF = 16;

    // Protocol and rounding constants of the checksum-length rule
    localparam int NEW_PROTO = 27;
    localparam int ROLL_BITS = 32;
    localparam int ROUND_UP  = 7;
    localparam int BYTE_BITS = 8;

    // Field widths
    localparam int LEN_W    = 63;
    localparam int BLK_W    = 32;
    localparam int STRONG_W = 5;
    localparam int FORCE_W  = 31;
    localparam int PROTO_W  = 8;
    localparam int IN_W     = 64;
    localparam int RES_W    = BLK_W + STRONG_W + LEN_W + BLK_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    // Shared subtract unit width and step counts
    localparam int ALU_W      = 35;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 63;
    localparam int CNT_W      = 6;

    // Register reset values
    localparam logic [FORCE_W-1:0]  FORCED_RST = '0;
    localparam logic [PROTO_W-1:0]  PROTO_RST  = 8'd27;
    localparam logic [STRONG_W-1:0] MINSL_RST  = 5'd2;

    typedef enum logic [1:0] {
        REG_FORCED = 2'd0,
        REG_PROTO  = 2'd1,
        REG_MINSL  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_SELECT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [FORCE_W-1:0]  forced_block_size;
        logic [PROTO_W-1:0]  proto_version;
        logic [STRONG_W-1:0] min_strong_len;
    } cfg_t;

    typedef struct packed {
        logic [BLK_W-1:0]    tail_bytes;
        logic [LEN_W-1:0]    block_count;
        logic [STRONG_W-1:0] strong_len;
        logic [BLK_W-1:0]    blk_size;
    } result_t;

endpackage

### design/delta_block_size_calc.sv
`timescale 1ns / 1ps

// Block sizing for a delta-transfer signature. Each request on the slave
// stream carries a file length; the master stream returns the block length
// (forced or a square root of the length truncated to a multiple of 8, at
// least MIN_BLOCK), the strong-checksum byte count, the block count and the
// tail remainder. Each request passes accept, a 32-step root pass, block
// select, a 63-step restoring divide and result hand-off; both passes
// share one 35-bit trial subtractor. The block takes one request at a
// time; a finished result waits in an output register, so the next
// request may be computed meanwhile. Configuration is to be written through
// the APB port only while the block is idle; the block does not check it.
module delta_block_size_calc
    import dbsc_pkg::*;
#(
    parameter int MIN_BLOCK  = MIN_BLOCK_DEF,
    parameter int BIAS       = BIAS_DEF,
    parameter int STRONG_LEN = STRONG_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // APB configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // length[62:0], zero pad[63]
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // blk_size[31:0], strong_len[36:32],
                                        // block_count[99:37], tail_bytes[131:100],
                                        // zero pad[135:132]
);

    cfg_t             cfg;
    result_t          res;
    logic             res_valid;
    logic             res_ready;
    logic             out_valid_reg;
    logic [RES_W-1:0] out_data_reg;

    dbsc_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbsc_seq #(
        .MIN_BLOCK  (MIN_BLOCK),
        .BIAS       (BIAS),
        .STRONG_LEN (STRONG_LEN)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_len    (s_tdata[LEN_W-1:0]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - RES_W)'(0), out_data_reg};

endmodule

### design/dbsc_apb.sv
`timescale 1ns / 1ps

module dbsc_apb
    import dbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [FORCE_W-1:0]  forced_reg;
    logic [PROTO_W-1:0]  proto_reg;
    logic [STRONG_W-1:0] minsl_reg;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forced_reg <= FORCED_RST;
            proto_reg  <= PROTO_RST;
            minsl_reg  <= MINSL_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FORCED: forced_reg <= pwdata[FORCE_W-1:0];
                REG_PROTO:  proto_reg  <= pwdata[PROTO_W-1:0];
                REG_MINSL:  minsl_reg  <= pwdata[STRONG_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_FORCED: prdata = {1'b0, forced_reg};
            REG_PROTO:  prdata = {24'd0, proto_reg};
            REG_MINSL:  prdata = {27'd0, minsl_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.forced_block_size = forced_reg;
    assign cfg.proto_version     = proto_reg;
    assign cfg.min_strong_len    = minsl_reg;

endmodule

### design/dbsc_sub.sv
`timescale 1ns / 1ps

// Trial subtract: difference and a no-borrow flag
module dbsc_sub
    import dbsc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic [ALU_W-1:0] diff,
    output logic             ge
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = !borrow;

endmodule

### design/dbsc_seq.sv
`timescale 1ns / 1ps

module dbsc_seq
    import dbsc_pkg::*;
#(
    parameter int MIN_BLOCK  = MIN_BLOCK_DEF,
    parameter int BIAS       = BIAS_DEF,
    parameter int STRONG_LEN = STRONG_LEN_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [LEN_W-1:0] in_len,
    input  cfg_t             cfg,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam logic [63:0]      MIN_SQ  = 64'(MIN_BLOCK) * 64'(MIN_BLOCK);
    localparam logic [BLK_W-1:0] MIN_BLK = BLK_W'(MIN_BLOCK);
    localparam int               B_W     = $clog2(BIAS + 2 * (LEN_W - 1) + 1);
    localparam int               NUM_OFF = ROLL_BITS - 1 - ROUND_UP;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [63:0]        work_reg;
    logic [ALU_W-1:0]   rem_reg;
    logic [BLK_W-1:0]   root_reg;
    logic [5:0]         lg_reg;
    logic               found_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BLK_W-2:0]   c_reg;
    logic [B_W-1:0]     b_reg;

    logic [ALU_W-1:0]   op_a, op_b, diff;
    logic               ge;
    logic               last_step;
    logic [4:0]         pair_idx;
    logic [BLK_W-1:0]   sq_trunc, heur_blk, blk_sel;
    logic [5:0]         s_raw, s_lo, s_fin;

    // Operand select for the shared subtract unit
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            op_a = {2'b00, rem_reg[BLK_W-1:0], work_reg[LEN_W-1]};
            op_b = {3'b000, blk_reg};
        end
        else
        begin
            op_a = {rem_reg[ALU_W-3:0], work_reg[63:62]};
            op_b = {1'b0, root_reg, 2'b01};
        end
    end

    dbsc_sub u_sub (
        .a    (op_a),
        .b    (op_b),
        .diff (diff),
        .ge   (ge)
    );

    always_comb
    begin
        case (state_reg)
            ST_SQRT: last_step = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
            ST_DIV:  last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));
            default: last_step = 1'b0;
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SQRT || state_reg == ST_DIV) && !last_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SQRT;
            ST_SQRT:   if (last_step) state_next = ST_SELECT;
            ST_SELECT: state_next = ST_DIV;
            ST_DIV:    if (last_step) state_next = ST_DONE;
            ST_DONE:   if (res_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    // Block length choice after the root is known
    assign pair_idx = 5'(SQRT_STEPS - 1) - cnt_reg[4:0];
    assign sq_trunc = {root_reg[BLK_W-1:3], 3'b000};
    assign heur_blk = (sq_trunc < MIN_BLK) ? MIN_BLK : sq_trunc;

    always_comb
    begin
        if (cfg.forced_block_size != '0)
            blk_sel = {1'b0, cfg.forced_block_size};
        else if (len_reg <= MIN_SQ[LEN_W-1:0])
            blk_sel = MIN_BLK;
        else
            blk_sel = heur_blk;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    len_reg   <= in_len;
                    work_reg  <= {1'b0, in_len};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    lg_reg    <= '0;
                    found_reg <= 1'b0;
                end
            end
            ST_SQRT:
            begin
                // one root digit per step; first nonzero pair marks the top bit
                if (!found_reg && (work_reg[63:62] != 2'b00))
                begin
                    found_reg <= 1'b1;
                    lg_reg    <= {pair_idx, work_reg[63]};
                end
                rem_reg  <= ge ? diff : op_a;
                root_reg <= {root_reg[BLK_W-2:0], ge};
                work_reg <= {work_reg[61:0], 2'b00};
            end
            ST_SELECT:
            begin
                blk_reg  <= blk_sel;
                c_reg    <= blk_sel[BLK_W-1:1];
                b_reg    <= B_W'(BIAS) + B_W'({lg_reg, 1'b0});
                work_reg <= {1'b0, len_reg};
                rem_reg  <= '0;
            end
            ST_DIV:
            begin
                // restoring divide, quotient bits shift in at the bottom
                rem_reg  <= ge ? diff : op_a;
                work_reg <= {work_reg[62:0], ge};
                // checksum bits drop by floor(log2 block), not below zero
                if (c_reg != '0 && b_reg != '0)
                begin
                    b_reg <= b_reg - B_W'(1);
                    c_reg <= c_reg >> 1;
                end
            end
            default: ;
        endcase
    end

    // Strong checksum length
    always_comb
    begin
        if (b_reg > B_W'(NUM_OFF))
            s_raw = 6'((b_reg - B_W'(NUM_OFF)) / BYTE_BITS);
        else
            s_raw = 6'd0;
        s_lo  = (s_raw < {1'b0, cfg.min_strong_len}) ? {1'b0, cfg.min_strong_len} : s_raw;
        s_fin = (s_lo > 6'(STRONG_LEN)) ? 6'(STRONG_LEN) : s_lo;
    end

    assign res.blk_size    = blk_reg;
    assign res.strong_len  = (cfg.proto_version < PROTO_W'(NEW_PROTO))
                             ? cfg.min_strong_len : s_fin[STRONG_W-1:0];
    assign res.block_count = work_reg[LEN_W-1:0]
                             + LEN_W'(rem_reg[BLK_W-1:0] != '0);
    assign res.tail_bytes  = rem_reg[BLK_W-1:0];

endmodule

### design/dbsc_checker.sv
`timescale 1ns / 1ps

`include "delta_block_size_calc_defines.svh"

module dbsc_checker
    import dbsc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled result holds
    `DBSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one request at a time: busy right after accept
    `DBSC_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // block length is never zero
    `DBSC_ASSERT_NOW(a_blk_nonzero, m_tvalid, m_tdata[31:0] != 32'd0, "zero block length")

    // remainder stays below the block length
    `DBSC_ASSERT_NOW(a_tail_lt_blk, m_tvalid, m_tdata[131:100] < m_tdata[31:0], "tail not below block length")

endmodule

bind delta_block_size_calc dbsc_checker u_dbsc_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dbsc_pkg::*;

    localparam int MIN_BLK = MIN_BLOCK_DEF;
    localparam int BIAS_B  = BIAS_DEF;
    localparam int MAX_SL  = STRONG_LEN_DEF;

    // Expected block sizing results, predicted from the current register copy
    class block_size_board;
        logic [FORCE_W-1:0]  forced;
        logic [PROTO_W-1:0]  proto;
        logic [STRONG_W-1:0] minsl;
        result_t             pending_sizes[$];
        int                  mismatches;

        function new();
            forced     = FORCED_RST;
            proto      = PROTO_RST;
            minsl      = MINSL_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FORCED: forced = value[FORCE_W-1:0];
                REG_PROTO:  proto  = value[PROTO_W-1:0];
                REG_MINSL:  minsl  = value[STRONG_W-1:0];
                default:    ;
            endcase
        endfunction

        function result_t predict_sizes(logic [LEN_W-1:0] len);
            logic [63:0] n, blk, trial, acc, scan, cnt, rem, sl_bytes;
            int          bits, num;
            result_t     r;
            n = {1'b0, len};
            // block length: forced, floor, or truncated square root
            if (forced != '0)
                blk = 64'(forced);
            else if (n <= 64'(MIN_BLK) * 64'(MIN_BLK))
                blk = 64'(MIN_BLK);
            else
            begin
                trial = 64'd1;
                scan  = n >> 2;
                while (scan != 0)
                begin
                    trial = trial << 1;
                    scan  = scan >> 2;
                end
                acc = '0;
                while (trial >= 64'(BYTE_BITS))
                begin
                    acc = acc | trial;
                    if (n < acc * acc)
                        acc = acc & ~trial;
                    trial = trial >> 1;
                end
                if (acc < 64'(MIN_BLK))
                    acc = 64'(MIN_BLK);
                blk = acc;
            end
            // strong checksum length
            if (proto < PROTO_W'(NEW_PROTO))
                sl_bytes = 64'(minsl);
            else
            begin
                bits = BIAS_B;
                scan = n >> 1;
                while (scan != 0)
                begin
                    bits = bits + 2;
                    scan = scan >> 1;
                end
                scan = blk >> 1;
                while (scan != 0 && bits != 0)
                begin
                    bits = bits - 1;
                    scan = scan >> 1;
                end
                num      = bits + 1 - ROLL_BITS + ROUND_UP;
                sl_bytes = (num > 0) ? 64'(num / BYTE_BITS) : 64'd0;
                if (sl_bytes < 64'(minsl))
                    sl_bytes = 64'(minsl);
                if (sl_bytes > 64'(MAX_SL))
                    sl_bytes = 64'(MAX_SL);
            end
            cnt = (n + (blk - 64'd1)) / blk;
            rem = n % blk;
            r.blk_size    = blk[BLK_W-1:0];
            r.strong_len  = sl_bytes[STRONG_W-1:0];
            r.block_count = cnt[LEN_W-1:0];
            r.tail_bytes  = rem[BLK_W-1:0];
            return r;
        endfunction

        function void note_request(logic [LEN_W-1:0] len);
            pending_sizes.push_back(predict_sizes(len));
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_sizes.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_sizes.pop_front();
            check_field("blk_size", 64'(want.blk_size), 64'(got.blk_size));
            check_field("strong_len", 64'(want.strong_len), 64'(got.strong_len));
            check_field("block_count", 64'(want.block_count), 64'(got.block_count));
            check_field("tail_bytes", 64'(want.tail_bytes), 64'(got.tail_bytes));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [3:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    block_size_board board;
    bit              quiet = 1'b0;
    int              sent_count = 0;

    delta_block_size_calc dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // APB write: setup phase, access phase, then bus idle
    task apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(addr[3:2], data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task set_sizing(input logic [30:0] forced, input logic [7:0] proto,
                    input logic [4:0] minsl);
        apb_write({REG_FORCED, 2'b00}, {$urandom_range(0, 1) == 1, forced});
        apb_write({REG_PROTO, 2'b00}, {24'($urandom), proto});
        apb_write({REG_MINSL, 2'b00}, 32'(minsl));
    endtask

    // Send one file length request, with random gap and an occasional drain
    task send_len(input logic [LEN_W-1:0] len);
        int gap;
        bit hold_off;
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        gap      = quiet ? 0 : $urandom_range(0, 6);
        hold_off = ($urandom_range(0, 59) == 0) || (sent_count == 100);
        if (gap > 0 || hold_off)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (hold_off)
            begin
                @(posedge clk);
                while (board.pending_sizes.size() != 0)
                    @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(len);
        sent_count++;
    endtask

    // Drop valid and wait for every outstanding result
    task drain_requests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_sizes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function logic [LEN_W-1:0] rand_len();
        logic [63:0] v, k;
        int          w;
        v = {$urandom, $urandom};
        w = $urandom_range(1, 63);
        case ($urandom_range(0, 9))
            0: rand_len = LEN_W'($urandom_range(0, 2000));
            1: rand_len = LEN_W'($urandom_range(489000, 492000));
            2: rand_len = v[LEN_W-1:0];
            3, 4: rand_len = LEN_W'(v[62:0] >> (63 - w));
            5: rand_len = {LEN_W{1'b1}} - LEN_W'($urandom_range(0, 1000));
            6:
            begin
                k = 64'($urandom_range(700, 32'd3037000499));
                k = k * k + 64'($urandom_range(0, 2)) - 64'd1;
                rand_len = k[LEN_W-1:0];
            end
            default: rand_len = LEN_W'(v[39:0] >> (40 - (w % 40)));
        endcase
    endfunction

    // Result side: random stall before each result
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_result(m_tdata[RES_W-1:0]);
        end
    end

    // Main sequence
    initial
    begin
        logic [LEN_W-1:0] edge_lens[$];
        logic [30:0]      f;
        board = new();
        edge_lens = '{63'd0, 63'd1, 63'd2, 63'd699, 63'd700, 63'd701,
                      63'd489999, 63'd490000, 63'd490001, 63'd491400, 63'd491401,
                      63'd491402, 63'h7FFF_FFFF_FFFF_FFFF, 63'h4000_0000_0000_0000,
                      63'h3FFF_FFFF_FFFF_FFFF, 63'h1_0000_0000,
                      63'd9223372030926249000, 63'd9223372030926249001,
                      63'd9223372030926249002, 63'h5555_5555_5555_5555,
                      63'h2AAA_AAAA_AAAA_AAAA};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lengths under reset settings
        foreach (edge_lens[i])
            send_len(edge_lens[i]);
        repeat (20) send_len(rand_len());

        for (int ph = 1; ph <= 10; ph++)
        begin
            drain_requests();
            case (ph)
                1: set_sizing(31'd0, 8'd255, 5'd16);
                2: set_sizing(31'd0, 8'd26, 5'd31);
                3: set_sizing(31'd0, 8'd0, 5'd0);
                4: set_sizing(31'd0, 8'd27, 5'd0);
                5: set_sizing(31'd1, 8'd27, 5'd1);
                6:
                begin
                    set_sizing(31'h7FFF_FFFF, 8'd100, 5'd5);
                    // unmapped register: write must be ignored
                    apb_write(4'hC, $urandom);
                end
                7: set_sizing(31'd8, 8'd30, 5'd16);
                10: set_sizing(31'd0, 8'd27, 5'd2);
                default:
                begin
                    f = ($urandom_range(0, 1) == 1) ? 31'($urandom_range(1, 100000)) : 31'd0;
                    set_sizing(f, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
                end
            endcase
            repeat (70) send_len(rand_len());
        end

        drain_requests();
        repeat (120) @(posedge clk);
        if (board.mismatches == 0 && board.pending_sizes.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/dbsc_pkg.sv
design/dbsc_apb.sv
design/dbsc_sub.sv
design/dbsc_seq.sv
design/delta_block_size_calc.sv
design/dbsc_checker.sv
tb/tb_top.sv
